// ----- hw/rtl/ffp_pkg.sv -----
// Shared types, constants and helpers for the frame fragment packetizer.
`default_nettype none

package ffp_pkg;

    localparam int unsigned MAX_PAYLOAD = 2048;
    localparam int unsigned PMAX_W      = 12;
    localparam int unsigned SIZE_W      = 24;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned TOTAL_W     = 16;
    localparam int unsigned HDR_LEN     = 12;
    localparam int unsigned HDR_CNT_W   = 4;
    localparam int unsigned NUM_W       = SIZE_W + 1;
    localparam int unsigned DIV_CNT_W   = 5;

    // Kind of word held in the queue between front and back.
    localparam logic [1:0] K_DATA       = 2'd0;
    localparam logic [1:0] K_START_OK   = 2'd1;
    localparam logic [1:0] K_START_DROP = 2'd2;

    typedef struct packed {
        logic [7:0]         data;
        logic [1:0]         kind;
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
        logic [TOTAL_W-1:0] total;
    } ffp_entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } ffp_qstat_t;

    function automatic logic [PMAX_W-1:0] eff_payload(input logic [PMAX_W-1:0] pm);
        logic [PMAX_W-1:0] lim;
        lim = PMAX_W'(MAX_PAYLOAD);
        if (pm > lim)
            return lim;
        return pm;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ffp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the fragment total.
`default_nettype none

module ffp_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ffp_pkg::NUM_W-1:0]    numer,
    input  wire logic [ffp_pkg::PMAX_W-1:0]   divisor,
    output logic                              done,
    output logic [ffp_pkg::NUM_W-1:0]         quotient
);

    logic                            run_reg, run_next;
    logic                            done_reg, done_next;
    logic [ffp_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ffp_pkg::PMAX_W-1:0]      rem_reg, rem_next;
    logic [ffp_pkg::NUM_W-1:0]       num_reg, num_next;
    logic [ffp_pkg::PMAX_W-1:0]      div_reg, div_next;
    logic [ffp_pkg::PMAX_W:0]        trial;
    logic [ffp_pkg::PMAX_W:0]        diff;
    logic                            ge;

    assign trial = {rem_reg, num_reg[ffp_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = numer;
            div_next  = divisor;
        end
        else if (run_reg)
        begin
            // The partial remainder stays below the divisor, so it fits its width.
            rem_next = ge ? diff[ffp_pkg::PMAX_W-1:0] : trial[ffp_pkg::PMAX_W-1:0];
            num_next = {num_reg[ffp_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ffp_pkg::DIV_CNT_W'(ffp_pkg::NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ffp_front.sv -----
// Front end: accepts input words, classifies frame starts and works out the fragment total.
`default_nettype none

module ffp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ffp_pkg::PMAX_W-1:0]    p_eff,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          frame_start,
    input  wire logic [ffp_pkg::SIZE_W-1:0]    frame_len,
    input  wire logic [ffp_pkg::STAMP_W-1:0]   timestamp,
    input  wire ffp_pkg::ffp_qstat_t           q_stat,
    output logic                               q_push,
    output ffp_pkg::ffp_entry_t                q_wdata
);

    localparam logic F_IDLE = 1'b0;
    localparam logic F_DIV  = 1'b1;

    logic                            state_reg, state_next;
    logic [7:0]                      byte_reg, byte_next;
    logic [ffp_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [ffp_pkg::STAMP_W-1:0]     stamp_reg, stamp_next;
    logic                            accept;
    logic                            div_start;
    logic                            div_done;
    logic [ffp_pkg::NUM_W-1:0]       numer;
    logic [ffp_pkg::NUM_W-1:0]       quotient;

    assign in_stall = (state_reg != F_IDLE) || q_stat.full;
    assign accept   = in_valid && !in_stall;
    // Rounding up: (size + p - 1) / p.
    assign numer    = {1'b0, frame_len} + ffp_pkg::NUM_W'(p_eff) - 1'b1;

    ffp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer),
        .divisor  (p_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        size_next     = size_reg;
        stamp_next    = stamp_reg;
        div_start     = 1'b0;
        q_push        = 1'b0;
        q_wdata.data  = data_byte;
        q_wdata.kind  = ffp_pkg::K_DATA;
        q_wdata.size  = frame_len;
        q_wdata.stamp = timestamp;
        q_wdata.total = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (!frame_start)
                    begin
                        q_push = 1'b1;
                    end
                    else if ((p_eff == '0) || (frame_len == '0))
                    begin
                        q_push       = 1'b1;
                        q_wdata.kind = ffp_pkg::K_START_DROP;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        byte_next  = data_byte;
                        size_next  = frame_len;
                        stamp_next = timestamp;
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                q_wdata.data  = byte_reg;
                q_wdata.size  = size_reg;
                q_wdata.stamp = stamp_reg;
                q_wdata.total = quotient[ffp_pkg::TOTAL_W-1:0];
                // A total that does not fit in sixteen bits drops the frame.
                if (quotient[ffp_pkg::NUM_W-1:ffp_pkg::TOTAL_W] != '0)
                    q_wdata.kind = ffp_pkg::K_START_DROP;
                else
                    q_wdata.kind = ffp_pkg::K_START_OK;
                if (div_done && !q_stat.full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        size_reg  <= size_next;
        stamp_reg <= stamp_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ffp_fifo.sv -----
// Two-entry queue between the front end and the packet sequencer.
`default_nettype none

module ffp_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ffp_pkg::ffp_entry_t  wdata,
    input  wire logic                 pop,
    output ffp_pkg::ffp_entry_t       rdata,
    output ffp_pkg::ffp_qstat_t       stat
);

    ffp_pkg::ffp_entry_t  mem_reg [2];
    logic                 wptr_reg, wptr_next;
    logic                 rptr_reg, rptr_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.valid = (cnt_reg != 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign rdata      = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ do_pop;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ffp_back.sv -----
// Packet sequencer: keeps the frame state, inserts headers and drives the output register.
`default_nettype none

module ffp_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [ffp_pkg::PMAX_W-1:0]   p_eff,
    input  wire ffp_pkg::ffp_entry_t          q_data,
    input  wire ffp_pkg::ffp_qstat_t          q_stat,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [7:0]                        out_byte,
    output logic                              packet_last,
    output logic                              frame_last,
    output logic [63:0]                       total_bytes_sent
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_HDR  = 2'd1;
    localparam logic [1:0] B_PAY  = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [ffp_pkg::HDR_CNT_W-1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]                       byte_reg, byte_next;
    logic [31:0]                      seq_reg, seq_next;
    logic [63:0]                      total_reg, total_next;
    logic [ffp_pkg::TOTAL_W-1:0]      idx_reg, idx_next;
    logic [ffp_pkg::TOTAL_W-1:0]      cnt_reg, cnt_next;
    logic [ffp_pkg::PMAX_W-1:0]       chunk_reg, chunk_next;
    logic [ffp_pkg::SIZE_W-1:0]       left_reg, left_next;
    logic [ffp_pkg::STAMP_W-1:0]      stamp_reg, stamp_next;
    logic                             active_reg, active_next;

    logic                             ovalid_reg, ovalid_next;
    logic [7:0]                       obyte_reg, obyte_next;
    logic                             oplast_reg, oplast_next;
    logic                             oflast_reg, oflast_next;
    logic [63:0]                      ototal_reg, ototal_next;

    logic                             emit_ok;
    logic                             emit;
    logic [7:0]                       emit_byte;
    logic                             emit_plast;
    logic                             emit_flast;
    logic                             do_pay;
    logic                             start_ok;
    logic                             start_any;
    logic                             eff_active;
    logic [ffp_pkg::SIZE_W-1:0]       eff_left;
    logic [ffp_pkg::PMAX_W-1:0]       eff_chunk;
    logic                             swallow;
    logic                             flast;
    logic                             plast;
    logic [7:0]                       hdr_byte;

    assign emit_ok    = !ovalid_reg || !out_stall;
    assign start_ok   = (q_data.kind == ffp_pkg::K_START_OK);
    assign start_any  = (q_data.kind != ffp_pkg::K_DATA);
    assign eff_active = start_any ? start_ok : active_reg;
    assign eff_left   = start_ok ? q_data.size : left_reg;
    assign eff_chunk  = start_ok ? '0 : chunk_reg;
    assign swallow    = !eff_active || (p_eff == '0) || (eff_left == '0);

    // Payload flags always come from the registered frame state.
    assign flast = (left_reg == ffp_pkg::SIZE_W'(1));
    assign plast = flast || (({1'b0, chunk_reg} + 1'b1) >= {1'b0, p_eff});

    always_comb
    begin
        case (hdr_cnt_reg)
            4'd0:    hdr_byte = seq_reg[31:24];
            4'd1:    hdr_byte = seq_reg[23:16];
            4'd2:    hdr_byte = seq_reg[15:8];
            4'd3:    hdr_byte = seq_reg[7:0];
            4'd4:    hdr_byte = stamp_reg[31:24];
            4'd5:    hdr_byte = stamp_reg[23:16];
            4'd6:    hdr_byte = stamp_reg[15:8];
            4'd7:    hdr_byte = stamp_reg[7:0];
            4'd8:    hdr_byte = idx_reg[15:8];
            4'd9:    hdr_byte = idx_reg[7:0];
            4'd10:   hdr_byte = cnt_reg[15:8];
            4'd11:   hdr_byte = cnt_reg[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        byte_next    = byte_reg;
        seq_next     = seq_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        chunk_next   = chunk_reg;
        left_next    = left_reg;
        stamp_next   = stamp_reg;
        active_next  = active_reg;
        ovalid_next  = ovalid_reg;
        obyte_next   = obyte_reg;
        oplast_next  = oplast_reg;
        oflast_next  = oflast_reg;
        ototal_next  = ototal_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        emit_byte    = 8'h00;
        emit_plast   = 1'b0;
        emit_flast   = 1'b0;
        do_pay       = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_stat.valid)
                begin
                    if (swallow)
                    begin
                        q_pop       = 1'b1;
                        active_next = 1'b0;
                    end
                    else if (eff_chunk == '0)
                    begin
                        // A fragment opens: load any new frame and send its header first.
                        q_pop        = 1'b1;
                        active_next  = 1'b1;
                        byte_next    = q_data.data;
                        hdr_cnt_next = '0;
                        state_next   = B_HDR;
                        if (start_ok)
                        begin
                            left_next  = q_data.size;
                            cnt_next   = q_data.total;
                            idx_next   = '0;
                            chunk_next = '0;
                            stamp_next = q_data.stamp;
                        end
                    end
                    else if (emit_ok)
                    begin
                        q_pop      = 1'b1;
                        emit       = 1'b1;
                        emit_byte  = q_data.data;
                        emit_plast = plast;
                        emit_flast = flast;
                        do_pay     = 1'b1;
                    end
                end
            end
            B_HDR:
            begin
                if (emit_ok)
                begin
                    emit         = 1'b1;
                    emit_byte    = hdr_byte;
                    hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    if (hdr_cnt_reg == ffp_pkg::HDR_CNT_W'(ffp_pkg::HDR_LEN - 1))
                    begin
                        seq_next   = seq_reg + 1'b1;
                        state_next = B_PAY;
                    end
                end
            end
            B_PAY:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_byte  = byte_reg;
                    emit_plast = plast;
                    emit_flast = flast;
                    do_pay     = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (do_pay)
        begin
            left_next  = left_reg - 1'b1;
            chunk_next = plast ? '0 : chunk_reg + 1'b1;
            if (plast)
                idx_next = idx_reg + 1'b1;
            if (flast)
                active_next = 1'b0;
        end

        if (emit)
        begin
            total_next  = total_reg + 1'b1;
            ovalid_next = 1'b1;
            obyte_next  = emit_byte;
            oplast_next = emit_plast;
            oflast_next = emit_flast;
            ototal_next = total_reg + 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            hdr_cnt_reg <= '0;
            seq_reg     <= '0;
            total_reg   <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            chunk_reg   <= '0;
            left_reg    <= '0;
            stamp_reg   <= '0;
            active_reg  <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
            seq_reg     <= seq_next;
            total_reg   <= total_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            chunk_reg   <= chunk_next;
            left_reg    <= left_next;
            stamp_reg   <= stamp_next;
            active_reg  <= active_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        obyte_reg  <= obyte_next;
        oplast_reg <= oplast_next;
        oflast_reg <= oflast_next;
        ototal_reg <= ototal_next;
    end

    assign out_valid        = ovalid_reg;
    assign out_byte         = obyte_reg;
    assign packet_last      = oplast_reg;
    assign frame_last       = oflast_reg;
    assign total_bytes_sent = ototal_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/frame_fragment_packetizer_core.sv -----
// Top level of the frame fragment packetizer: config register, front end, queue and sequencer.
//
// Channel   Direction  Handshake            Word
// in        input      in_valid / in_stall  data_byte, frame_start, frame_len, timestamp
// out       output     out_valid/out_stall  out_byte, packet_last, frame_last, total_bytes_sent
// cfg       input      cfg_wen              cfg_wdata (payload_max)
//
// Inside a fragment the output runs at one word per cycle unless stalled or the queue is empty.
// Opening a fragment costs a decode step in the sequencer, then the twelve header bytes.
// An accepted frame start holds the input while the front end's one-bit-per-cycle
// divider works out the fragment total; other words go straight into the queue.
// Reset is asynchronous and clears all counters and the frame state.
// A two-word queue lets the input run on while the output is stalled, and vice versa.
`default_nettype none

module frame_fragment_packetizer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [ffp_pkg::PMAX_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          frame_start,
    input  wire logic [ffp_pkg::SIZE_W-1:0]    frame_len,
    input  wire logic [ffp_pkg::STAMP_W-1:0]   timestamp,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         out_byte,
    output logic                               packet_last,
    output logic                               frame_last,
    output logic [63:0]                        total_bytes_sent
);

    logic [ffp_pkg::PMAX_W-1:0]   payload_max_reg;
    logic [ffp_pkg::PMAX_W-1:0]   p_eff;
    logic                         q_push;
    logic                         q_pop;
    ffp_pkg::ffp_entry_t          q_wdata;
    ffp_pkg::ffp_entry_t          q_rdata;
    ffp_pkg::ffp_qstat_t          q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            payload_max_reg <= '0;
        else if (cfg_wen)
            payload_max_reg <= cfg_wdata;
    end

    // Settings above the largest payload are clamped to it.
    assign p_eff = ffp_pkg::eff_payload(payload_max_reg);

    ffp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .p_eff       (p_eff),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .frame_len   (frame_len),
        .timestamp   (timestamp),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    ffp_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    ffp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .p_eff            (p_eff),
        .q_data           (q_rdata),
        .q_stat           (q_stat),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .packet_last      (packet_last),
        .frame_last       (frame_last),
        .total_bytes_sent (total_bytes_sent)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ffp_checker.sv -----
// Port-level checks on the packetizer's output stream, bound to the top level.
`default_nettype none

module ffp_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [7:0]                    out_byte,
    input  wire logic                          packet_last,
    input  wire logic                          frame_last,
    input  wire logic [63:0]                   total_bytes_sent
);

    // The last word of a frame always closes its packet too.
    a_frame_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> packet_last)
        else $error("frame_last without packet_last");

    // An output word right after an accepted one carries a byte count one higher.
    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid |->
            total_bytes_sent == $past(total_bytes_sent) + 64'd1)
        else $error("byte count did not advance by one");

    // A stalled output word is held unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(packet_last)
            && $stable(frame_last) && $stable(total_bytes_sent))
        else $error("stalled output word changed");

endmodule

bind frame_fragment_packetizer_core ffp_checker u_ffp_checker (.*);

`default_nettype wire

// ----- test/frame_fragment_packetizer_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the frame fragment packetizer core: directed table, then random frames.
module frame_fragment_packetizer_core_tb;

    localparam int unsigned SIZE_W       = ffp_pkg::SIZE_W;
    localparam int unsigned PMAX_W       = ffp_pkg::PMAX_W;
    localparam int unsigned MAX_FRAGS    = 16'hFFFF;
    localparam int          DRAIN_CYCLES = 48;
    localparam int          LONG_HOLD    = 400;
    localparam int          RANDOM_ITEMS = 330;

    typedef struct packed {
        logic [7:0]  data;
        logic        plast;
        logic        flast;
        logic [63:0] count;
    } pkt_word_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              start;
        logic [SIZE_W-1:0] size;
        logic [31:0]       stamp;
    } frame_word_t;

    typedef enum logic [1:0] {ROW_CHECKED, ROW_SILENT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        frame_word_t       w;
        logic [PMAX_W-1:0] pmax;
    } plan_row_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wen     = 1'b0;
    logic [PMAX_W-1:0] cfg_wdata   = '0;
    logic              in_valid    = 1'b0;
    logic [7:0]        data_byte   = '0;
    logic              frame_start = 1'b0;
    logic [SIZE_W-1:0] frame_len   = '0;
    logic [31:0]       timestamp   = '0;
    logic              out_stall   = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              packet_last;
    logic              frame_last;
    logic [63:0]       total_bytes_sent;

    frame_fragment_packetizer_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wen          (cfg_wen),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .frame_start      (frame_start),
        .frame_len        (frame_len),
        .timestamp        (timestamp),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .packet_last      (packet_last),
        .frame_last       (frame_last),
        .total_bytes_sent (total_bytes_sent)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state, mirroring the block after reset.
    logic [PMAX_W-1:0] pmax_copy   = '0;
    logic [31:0]       pkt_seq     = '0;
    logic [63:0]       bytes_out   = '0;
    logic [15:0]       frag_index  = '0;
    logic [15:0]       frag_count  = '0;
    logic [11:0]       chunk_pos   = '0;
    logic [23:0]       bytes_left  = '0;
    logic [31:0]       frame_stamp = '0;
    bit                in_frame    = 1'b0;
    bit                record_words = 1'b1;

    pkt_word_t pending_words[$];
    int        fail_count = 0;
    int        burst_left = 0;
    int        hold_asks  = 0;
    int        hold_seen  = 0;
    int        hold_left  = 0;
    int        rx_mode    = 0;
    int        rx_mode_left = 0;
    int        rx_phase   = 0;
    int        counted    = 0;

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 20)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic pl, input logic fl);
        bytes_out++;
        if (record_words)
            pending_words.push_back('{b, pl, fl, bytes_out});
    endtask

    // Works out the packet words caused by one accepted frame word.
    task automatic packetize_word(input frame_word_t w, output int n);
        int unsigned p;
        int unsigned frags;
        logic [95:0] hdr;
        logic        plast;
        logic        flast;
        n = 0;
        p = (pmax_copy > ffp_pkg::MAX_PAYLOAD) ? ffp_pkg::MAX_PAYLOAD : pmax_copy;
        if (w.start)
        begin
            in_frame = 1'b0;
            if (p != 0 && w.size != 0)
            begin
                frags = (int'(w.size) + p - 1) / p;
                if (frags <= MAX_FRAGS)
                begin
                    in_frame    = 1'b1;
                    bytes_left  = w.size;
                    frag_count  = frags[15:0];
                    frag_index  = '0;
                    chunk_pos   = '0;
                    frame_stamp = w.stamp;
                end
            end
        end
        if (!in_frame)
            return;
        // A payload limit cleared mid-frame abandons the frame.
        if (p == 0 || bytes_left == 0)
        begin
            in_frame = 1'b0;
            return;
        end
        if (chunk_pos == 0)
        begin
            hdr = {pkt_seq, frame_stamp, frag_index, frag_count};
            pkt_seq++;
            for (int i = 11; i >= 0; i--)
            begin
                put_byte(hdr[i*8 +: 8], 1'b0, 1'b0);
                n++;
            end
        end
        flast = (bytes_left == 1);
        plast = flast || (int'(chunk_pos) + 1 >= p);
        put_byte(w.data, plast, flast);
        n++;
        bytes_left--;
        chunk_pos++;
        if (plast)
        begin
            chunk_pos = '0;
            frag_index++;
        end
        if (flast)
            in_frame = 1'b0;
    endtask

    task automatic send_word(input frame_word_t w, output int n);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        data_byte   <= w.data;
        frame_start <= w.start;
        frame_len   <= w.size;
        timestamp   <= w.stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        packetize_word(w, n);
    endtask

    // Holds the sender until every expected word has come and the block has settled.
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pmax(input logic [PMAX_W-1:0] v);
        drain_block();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        pmax_copy = v;
    endtask

    function automatic logic [PMAX_W-1:0] pick_pmax();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return '0;
            1:       return 12'd1;
            2:       return 12'd2048;
            3:       return 12'hFFF;
            4:       return PMAX_W'($urandom);
            default: return PMAX_W'($urandom_range(1, 9));
        endcase
    endfunction

    function automatic plan_row_t row(input row_kind_t kind, input logic [7:0] data,
                                      input logic start, input logic [SIZE_W-1:0] size,
                                      input logic [31:0] stamp, input logic [PMAX_W-1:0] pmax);
        plan_row_t r;
        r.kind    = kind;
        r.w.data  = data;
        r.w.start = start;
        r.w.size  = size;
        r.w.stamp = stamp;
        r.pmax    = pmax;
        return r;
    endfunction

    // Sends count words of one frame; only the first carries the start mark when asked.
    task automatic send_frame(input bit with_start, input logic [SIZE_W-1:0] size,
                              input int count);
        frame_word_t w;
        int          n;
        for (int i = 0; i < count; i++)
        begin
            w.data  = 8'($urandom);
            w.start = with_start && (i == 0);
            w.size  = (w.start) ? size : SIZE_W'($urandom);
            w.stamp = $urandom;
            send_word(w, n);
            counted++;
        end
    endtask

    always @(posedge clk)
    begin : rx_side
        pkt_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
                note_mismatch($sformatf("unexpected word %02h", out_byte));
            else
            begin
                want = pending_words.pop_front();
                if (out_byte !== want.data)
                    note_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
                if (packet_last !== want.plast)
                    note_mismatch($sformatf("packet_last %b, want %b at byte %0d",
                                            packet_last, want.plast, want.count));
                if (frame_last !== want.flast)
                    note_mismatch($sformatf("frame_last %b, want %b at byte %0d",
                                            frame_last, want.flast, want.count));
                if (total_bytes_sent !== want.count)
                    note_mismatch($sformatf("total_bytes_sent %0d, want %0d",
                                            total_bytes_sent, want.count));
            end
        end
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left--;
            rx_phase++;
            case (rx_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 1) == 1);
                2:       out_stall <= (rx_phase % 3 == 0);
                default: out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin
        #2_000_000;
        $display("frame_fragment_packetizer_core test failed");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t   plan[$];
        int          n;
        int          kind;
        int          p_now;
        int          size;
        int          sent;
        int          since_cfg;
        int          cfg_every;
        int          wait_left;

        // Unconfigured block: everything is swallowed; then a limit of one, a zero-length start and a two-byte frame.
        plan.push_back(row(ROW_SILENT,  8'hA5, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_SILENT,  8'hFF, 1'b1, 24'd5, 32'h12345678, 12'd0));
        plan.push_back(row(ROW_SILENT,  8'h00, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CFG,     8'h00, 1'b0, 24'd0, 32'h0, 12'd1));
        plan.push_back(row(ROW_SILENT,  8'h5A, 1'b1, 24'd0, 32'hFFFFFFFF, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'hFF, 1'b1, 24'd2, 32'hFFFFFFFF, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'h00, 1'b0, 24'hFFFFFF, 32'h0, 12'd0));
        // Out-of-range limit is clamped; then an early restart.
        plan.push_back(row(ROW_CFG,     8'h00, 1'b0, 24'd0, 32'h0, 12'hFFF));
        plan.push_back(row(ROW_CHECKED, 8'h5A, 1'b1, 24'd3, 32'h00000000, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'hA5, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'h81, 1'b1, 24'd1, 32'h80000001, 12'd0));
        // Fragment total just above and just at the 16-bit limit.
        plan.push_back(row(ROW_CFG,     8'h00, 1'b0, 24'd0, 32'h0, 12'd255));
        plan.push_back(row(ROW_SILENT,  8'h11, 1'b1, 24'hFFFFFF, 32'h0, 12'd0));
        plan.push_back(row(ROW_SILENT,  8'h22, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CFG,     8'h00, 1'b0, 24'd0, 32'h0, 12'd256));
        plan.push_back(row(ROW_SILENT,  8'h00, 1'b1, 24'd16776961, 32'h0, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'h33, 1'b1, 24'd16776960, 32'hCAFE0001, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'h44, 1'b0, 24'd0, 32'h0, 12'd0));
        // Limit lowered mid-frame, then cleared mid-frame.
        plan.push_back(row(ROW_CFG,     8'h00, 1'b0, 24'd0, 32'h0, 12'd3));
        plan.push_back(row(ROW_CHECKED, 8'h55, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'h66, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CFG,     8'h00, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_SILENT,  8'h77, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CFG,     8'h00, 1'b0, 24'd0, 32'h0, 12'd2));
        plan.push_back(row(ROW_SILENT,  8'h88, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'hC3, 1'b1, 24'd5, 32'h0F0F0F0F, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'h3C, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'hF0, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'h0F, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CHECKED, 8'h01, 1'b0, 24'd0, 32'h0, 12'd0));
        plan.push_back(row(ROW_CFG,     8'h00, 1'b0, 24'd0, 32'h0, 12'd2048));
        plan.push_back(row(ROW_CHECKED, 8'hFE, 1'b1, 24'h800000, 32'h7FFFFFFF, 12'd0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_pmax(plan[i].pmax);
            else
            begin
                record_words = (plan[i].kind == ROW_CHECKED);
                send_word(plan[i].w, n);
                record_words = 1'b1;
            end
        end

        // Receiver holds off while the sender keeps offering words.
        hold_asks++;
        since_cfg = 0;
        cfg_every = $urandom_range(4, 12);
        counted   = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (since_cfg >= cfg_every)
            begin
                write_pmax(pick_pmax());
                since_cfg = 0;
                cfg_every = $urandom_range(4, 12);
            end
            since_cfg++;
            p_now = (pmax_copy > ffp_pkg::MAX_PAYLOAD) ? ffp_pkg::MAX_PAYLOAD : pmax_copy;
            kind  = $urandom_range(0, 99);
            if (kind < 65)
            begin
                size = $urandom_range(1, (p_now >= 1 && p_now <= 9) ? 3 * p_now + 2 : 40);
                send_frame(1'b1, SIZE_W'(size), size);
            end
            else if (kind < 75)
            begin
                // Cut short: the next frame start abandons it.
                size = $urandom_range(8, 200);
                send_frame(1'b1, SIZE_W'(size), $urandom_range(1, 7));
            end
            else if (kind < 82)
                send_frame(1'b0, '0, $urandom_range(1, 3));
            else if (kind < 88)
            begin
                size = ($urandom_range(0, 1) == 1) ? 0 : ($urandom | 32'h00800000);
                send_frame(1'b1, SIZE_W'(size), $urandom_range(1, 3));
            end
            else if (kind < 94)
            begin
                size = $urandom_range(6, 30);
                sent = $urandom_range(1, size - 1);
                send_frame(1'b1, SIZE_W'(size), sent);
                write_pmax(pick_pmax());
                send_frame(1'b0, '0, size - sent);
            end
            else
                send_frame(1'b1, SIZE_W'($urandom), $urandom_range(1, 4));
        end

        in_valid <= 1'b0;
        wait_left = 20000;
        while (pending_words.size() != 0 && wait_left > 0)
        begin
            @(posedge clk);
            wait_left--;
        end
        if (pending_words.size() != 0)
            note_mismatch($sformatf("%0d expected words never came", pending_words.size()));
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("frame_fragment_packetizer_core test passed");
        else
            $display("frame_fragment_packetizer_core test failed");
        $finish;
    end

endmodule
